>>> rtl/core/krt_pkg.sv
`default_nettype none

package krt_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [6:0]         position;
    logic signed [31:0] lookup_key;
    logic [63:0]        record_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic [63:0]        found_payload;
    logic [6:0]         fill_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/keyed_record_table_unit.sv
`default_nettype none

// Fixed-capacity unordered record table held in one single-port-read,
// single-port-write memory. A request is taken when start_i is high and
// busy_o is low, and its response is presented on rsp_o for exactly one cycle
// with done_o high; the receiver cannot stall, so it must capture the
// response in that cycle. Insert, and any request that fails at once (full
// table, bad position, empty table), answers in the cycle after acceptance
// and leaves busy_o low, so requests of that kind can follow back to back.
// A read by position passes through ST_READ, where the registered memory word
// forms the response. Find and remove walk the filled entries one per cycle
// through the read port, up to a match or the last filled entry; remove
// then passes through ST_LAST to read the last entry and write it over the
// match. Reset clears the state, done_o and the fill count but not the memory
// contents, and no entry at or beyond the fill count is ever returned.
module keyed_record_table_unit #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  krt_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            done_o,
  output krt_pkg::rsp_t   rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int EW = 32 + PAYLOAD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_LAST = 2'd3;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic [1:0]    op_q, op_d;
  logic [31:0]   key_q, key_d;
  logic          done_q, done_d;
  krt_pkg::rsp_t rsp_q, rsp_d;

  logic          accept;
  logic [6:0]    pos_m1;
  logic          pos_valid;
  logic [AW-1:0] last_idx;
  logic [31:0]   rd_key;
  logic          key_hit;
  logic          scan_end;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign pos_m1    = req_i.position - 7'd1;
  assign pos_valid = (req_i.position != 7'd0) && (PW'(req_i.position) <= PW'(count_q));
  assign last_idx  = AW'(count_q - CW'(1));
  assign rd_key    = rdata_q[EW-1 -: 32];
  assign key_hit   = (rd_key == key_q);
  assign scan_end  = (CW'(scan_idx_q) == (count_q - CW'(1)));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    match_idx_d = match_idx_q;
    op_d        = op_q;
    key_d       = key_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    raddr       = '0;
    we          = 1'b0;
    waddr       = AW'(count_q);
    wdata       = {req_i.lookup_key, req_i.record_payload[PAYLOAD_BITS-1:0]};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = req_i.req_type;
          key_d = req_i.lookup_key;
          rsp_d.found_key     = '0;
          rsp_d.found_payload = '0;
          rsp_d.status        = krt_pkg::STATUS_MISS;
          rsp_d.fill_count    = 7'(count_q);
          case (req_i.req_type)
            krt_pkg::REQ_INSERT: begin
              done_d = 1'b1;
              if (count_q >= CW'(CAPACITY)) begin
                rsp_d.status = krt_pkg::STATUS_FULL;
              end else begin
                we               = 1'b1;
                count_d          = count_q + CW'(1);
                rsp_d.status     = krt_pkg::STATUS_OK;
                rsp_d.fill_count = 7'(count_q + CW'(1));
              end
            end
            krt_pkg::REQ_READ: begin
              raddr = AW'(pos_m1);
              if (pos_valid) begin
                state_d = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              raddr      = '0;
              scan_idx_d = '0;
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        done_d              = 1'b1;
        rsp_d.status        = krt_pkg::STATUS_OK;
        rsp_d.found_key     = rd_key;
        rsp_d.found_payload = 64'(rdata_q[PAYLOAD_BITS-1:0]);
        state_d             = ST_IDLE;
      end

      ST_SCAN: begin
        // The read of the next entry is issued every cycle (on a remove hit the last
        // entry is read instead), so rdata_q always holds the entry at scan_idx_q.
        raddr      = scan_idx_q + AW'(1);
        scan_idx_d = scan_idx_q + AW'(1);
        if (key_hit) begin
          if (op_q == krt_pkg::REQ_FIND) begin
            done_d              = 1'b1;
            rsp_d.status        = krt_pkg::STATUS_OK;
            rsp_d.found_key     = rd_key;
            rsp_d.found_payload = 64'(rdata_q[PAYLOAD_BITS-1:0]);
            state_d             = ST_IDLE;
          end else begin
            raddr       = last_idx;
            match_idx_d = scan_idx_q;
            state_d     = ST_LAST;
          end
        end else if (scan_end) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_LAST: begin
        // rdata_q holds the last filled entry; move it over the match.
        we               = 1'b1;
        waddr            = match_idx_q;
        wdata            = rdata_q;
        count_d          = count_q - CW'(1);
        done_d           = 1'b1;
        rsp_d.status     = krt_pkg::STATUS_OK;
        rsp_d.fill_count = 7'(count_q - CW'(1));
        state_d          = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    match_idx_q <= match_idx_d;
    op_q        <= op_d;
    key_q       <= key_d;
    rsp_q       <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
